### rtl/pbrf_pkg.sv
// Shared constants, types and a helper function of the prebuffered byte ring FIFO.
package pbrf_pkg;

  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned MAX_TAKE = 64;

  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned OCC_W   = $clog2(DEPTH + 1);
  localparam int unsigned TK_W    = $clog2(MAX_TAKE + 1);
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned AMT_W   = 12;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned AVAIL_W = 11;
  localparam int unsigned SUM_W   = ((AMT_W > OCC_W) ? AMT_W : OCC_W) + 1;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_BIG  = 2'd2,
    ST_NRDY = 2'd3
  } status_e;

  typedef struct packed {
    logic [AW-1:0]    rd;
    logic [AW-1:0]    wr;
    logic [OCC_W-1:0] occ;
    logic             pre;
    logic [AMT_W-1:0] rem;
    logic             rej;
    logic             ovf;
  } ring_t;

  localparam ring_t RING_EMPTY = '{
    rd:  '0,
    wr:  '0,
    occ: '0,
    pre: 1'b1,
    rem: '0,
    rej: 1'b0,
    ovf: 1'b0
  };

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] pos,
                                             input logic [OCC_W-1:0] len);
    logic [OCC_W:0] nxt;
    nxt = {1'b0, OCC_W'(pos)} + (OCC_W + 1)'(1);
    return (nxt >= {1'b0, len}) ? '0 : AW'(nxt);
  endfunction

endpackage

### rtl/prebuffered_byte_ring_fifo_unit.sv
// Top level of the prebuffered byte ring FIFO: command sequencer, ring memory and result register.
// A put, clear or unknown command gives one result, so puts stream at one item per cycle while
// the result side accepts. A take of n bytes holds the input: first a registered read of the
// byte memory, then one byte per cycle while the result side does not stall, with the next
// read issued while the previous byte is handed to the result register. A take that is refused
// or finds nothing to read gives one result. The user must write the buffer length register
// only while the block is idle; the block itself does not enforce this. A write empties the ring.
module prebuffered_byte_ring_fifo_unit import pbrf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LEN_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [BYTE_W-1:0]  data_byte_i,
  input  logic               burst_start_i,
  input  logic [AMT_W-1:0]   amount_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [BYTE_W-1:0]  data_out_o,
  output logic               data_valid_o,
  output logic [1:0]         status_o,
  output logic [CNT_W-1:0]   bytes_returned_o,
  output logic               last_o,
  output logic [AVAIL_W-1:0] available_o
);

  typedef enum logic {
    S_IDLE,
    S_TAKE
  } state_e;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic               dv;
    status_e            status;
    logic [CNT_W-1:0]   cnt;
    logic               last;
    logic [AVAIL_W-1:0] avail;
  } res_t;

  state_e           state_q, state_d;
  ring_t            ring_q, ring_d;
  logic [OCC_W-1:0] bl_q, bl_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;
  logic [TK_W-1:0]  iss_q, iss_d;
  logic [TK_W-1:0]  n_q, n_d;
  logic [TK_W-1:0]  cnt_q, cnt_d;
  logic             pend_q, pend_d;

  ring_t            put_ring;
  logic             put_we;
  status_e          put_status;
  logic             out_free;
  logic             in_acc;
  logic             load;
  logic             deliver;
  logic             issue;
  logic             ram_re;
  logic [BYTE_W-1:0] ram_rdata;
  logic [TK_W-1:0]  amt_sat;
  logic [TK_W-1:0]  take_n;
  logic [OCC_W-1:0] occ_dec;
  logic [OCC_W-1:0] cfg_len;

  pbrf_put u_put (
    .ring_i   (ring_q),
    .bl_i     (bl_q),
    .start_i  (burst_start_i),
    .len_i    (amount_i),
    .ring_o   (put_ring),
    .we_o     (put_we),
    .status_o (put_status)
  );

  pbrf_ram #(
    .DATA_W     (BYTE_W),
    .ADDR_DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (command_i == CMD_PUT) && put_we),
    .waddr_i (ring_q.wr),
    .wdata_i (data_byte_i),
    .re_i    (ram_re),
    .raddr_i (ring_q.rd),
    .rdata_o (ram_rdata)
  );

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && out_free;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign amt_sat = (amount_i > AMT_W'(MAX_TAKE)) ? TK_W'(MAX_TAKE) : TK_W'(amount_i);
  assign take_n  = (ring_q.occ < OCC_W'(amt_sat)) ? TK_W'(ring_q.occ) : amt_sat;
  assign occ_dec = ring_q.occ - OCC_W'(1);

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_len = OCC_W'(1);
    end else if (OCC_W'(cfg_data_i) > OCC_W'(DEPTH)) begin
      cfg_len = OCC_W'(DEPTH);
    end else begin
      cfg_len = OCC_W'(cfg_data_i);
    end
  end

  always_comb begin
    state_d = state_q;
    ring_d  = ring_q;
    bl_d    = bl_q;
    iss_d   = iss_q;
    n_d     = n_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    load    = 1'b0;
    ram_re  = 1'b0;
    deliver = 1'b0;
    issue   = 1'b0;
    out_d   = out_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          load         = 1'b1;
          out_d.data   = '0;
          out_d.dv     = 1'b0;
          out_d.status = ST_OK;
          out_d.cnt    = '0;
          out_d.last   = 1'b1;
          out_d.avail  = ring_q.pre ? '0 : AVAIL_W'(ring_q.occ);
          case (command_i)
            CMD_PUT: begin
              ring_d       = put_ring;
              out_d.status = put_status;
              out_d.avail  = put_ring.pre ? '0 : AVAIL_W'(put_ring.occ);
            end
            CMD_TAKE: begin
              if (ring_q.pre) begin
                out_d.status = ST_NRDY;
              end else if (take_n == '0) begin
                if (ring_q.occ == '0) begin
                  ring_d.pre = 1'b1;
                end
              end else begin
                load    = 1'b0;
                state_d = S_TAKE;
                n_d     = take_n;
                iss_d   = take_n;
                cnt_d   = '0;
                pend_d  = 1'b0;
              end
            end
            CMD_CLEAR: begin
              ring_d      = RING_EMPTY;
              out_d.avail = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_TAKE: begin
        deliver = pend_q && out_free;
        issue   = (iss_q != '0) && (!pend_q || deliver);
        if (issue) begin
          ram_re    = 1'b1;
          ring_d.rd = wrap_inc(ring_q.rd, bl_q);
          iss_d     = iss_q - TK_W'(1);
        end
        if (deliver) begin
          load         = 1'b1;
          ring_d.occ   = occ_dec;
          cnt_d        = cnt_q + TK_W'(1);
          out_d.data   = ram_rdata;
          out_d.dv     = 1'b1;
          out_d.status = ST_OK;
          out_d.cnt    = CNT_W'(cnt_q + TK_W'(1));
          out_d.last   = (cnt_q + TK_W'(1)) == n_q;
          out_d.avail  = AVAIL_W'(occ_dec);
          if ((cnt_q + TK_W'(1)) == n_q) begin
            state_d = S_IDLE;
            if (occ_dec == '0) begin
              ring_d.pre = 1'b1;
            end
          end
        end
        pend_d = issue ? 1'b1 : (deliver ? 1'b0 : pend_q);
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_valid_i) begin
      bl_d   = cfg_len;
      ring_d = RING_EMPTY;
    end

    out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ring_q      <= RING_EMPTY;
      bl_q        <= OCC_W'(DEPTH);
      out_valid_q <= 1'b0;
      iss_q       <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      ring_q      <= ring_d;
      bl_q        <= bl_d;
      out_valid_q <= out_valid_d;
      iss_q       <= iss_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign data_out_o       = out_q.data;
  assign data_valid_o     = out_q.dv;
  assign status_o         = out_q.status;
  assign bytes_returned_o = out_q.cnt;
  assign last_o           = out_q.last;
  assign available_o      = out_q.avail;

endmodule

### rtl/pbrf_ram.sv
// Generic single-port-write, registered-read synchronous RAM.
module pbrf_ram #(
  parameter int unsigned DATA_W     = 8,
  parameter int unsigned ADDR_DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(ADDR_DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]             wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(ADDR_DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]             rdata_o
);

  logic [DATA_W-1:0] mem_q [ADDR_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pbrf_put.sv
// Next ring state and status for one put byte, including burst checks and drop-oldest.
module pbrf_put import pbrf_pkg::*; (
  input  ring_t            ring_i,
  input  logic [OCC_W-1:0] bl_i,
  input  logic             start_i,
  input  logic [AMT_W-1:0] len_i,
  output ring_t            ring_o,
  output logic             we_o,
  output status_e          status_o
);

  logic [SUM_W-1:0] bl_s;
  logic [SUM_W-1:0] len_s;
  logic [SUM_W-1:0] occ_s;
  logic [SUM_W-1:0] occ_a;
  logic [SUM_W-1:0] occ_1;
  logic [SUM_W-1:0] cap;
  logic [SUM_W-1:0] occ_f;
  logic [SUM_W-1:0] wr_n;
  logic             too_big;
  logic             act_ovf;
  logic             act_rej;
  logic [AMT_W-1:0] act_rem;

  always_comb begin
    bl_s    = SUM_W'(bl_i);
    len_s   = SUM_W'(len_i);
    occ_s   = SUM_W'(ring_i.occ);
    too_big = len_s > bl_s;
    act_ovf = start_i ? ((occ_s + len_s) > bl_s) : ring_i.ovf;
    act_rej = start_i ? 1'b0 : ring_i.rej;
    act_rem = start_i ? len_i : ring_i.rem;

    if (start_i && act_ovf) begin
      occ_a = (len_s < bl_s) ? (bl_s - SUM_W'(1) - len_s) : '0;
    end else begin
      occ_a = occ_s;
    end
    occ_1 = occ_a + SUM_W'(1);
    cap   = act_ovf ? (bl_s - SUM_W'(1)) : bl_s;
    occ_f = (occ_1 > cap) ? cap : occ_1;
    wr_n  = ((SUM_W'(ring_i.wr) + SUM_W'(1)) >= bl_s) ? '0 : (SUM_W'(ring_i.wr) + SUM_W'(1));

    ring_o   = ring_i;
    we_o     = 1'b0;
    status_o = ST_OK;

    if (start_i && too_big) begin
      ring_o.rej = 1'b1;
      ring_o.ovf = 1'b0;
      ring_o.rem = len_i - AMT_W'(1);
      status_o   = ST_BIG;
    end else if (start_i && (len_i == '0)) begin
      ring_o.rej = 1'b0;
      ring_o.ovf = 1'b0;
      ring_o.rem = '0;
    end else if (act_rem != '0) begin
      ring_o.rej = act_rej;
      ring_o.ovf = act_ovf;
      ring_o.rem = act_rem - AMT_W'(1);
      if (act_rej) begin
        status_o = ST_BIG;
      end else begin
        we_o       = 1'b1;
        ring_o.wr  = AW'(wr_n);
        ring_o.occ = OCC_W'(occ_f);
        if (occ_f > wr_n) begin
          ring_o.rd = AW'(wr_n + bl_s - occ_f);
        end else begin
          ring_o.rd = AW'(wr_n - occ_f);
        end
        if (occ_f > (bl_s >> 1)) begin
          ring_o.pre = 1'b0;
        end
        status_o = act_ovf ? ST_OVF : ST_OK;
      end
    end
  end

endmodule
